>>> rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task slot scheduler: shared package
// Table size, field widths, transaction payload types, status and command
// codes used by the slot cells and by the top level.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Number of task slots in the table, and widths that follow from it.
  localparam int unsigned MAX_TASKS = 8;
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);

  // Fixed field widths.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned ID_W  = 8;
  localparam int unsigned IVL_W = 16;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned AC_W  = 4;

  // Operation codes of an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // Status codes of a result transaction.
  typedef enum logic [ST_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_IDLE      = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // Commands broadcast to every cell.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_ADD,
    CMD_REMOVE,
    CMD_DECR,
    CMD_SCAN
  } cmd_e;

  // Input transaction payload.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  task_id;
    logic [IVL_W-1:0] interval;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] task_id_res;
    logic [AC_W-1:0] active_count;
    logic            last;
  } out_t;

  // Contents of one task slot.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [IVL_W-1:0] interval;
    logic [IVL_W-1:0] countdown;
  } slot_t;

  // Command broadcast from the controller to the cells.
  typedef struct packed {
    cmd_e             cmd;
    logic [ID_W-1:0]  key_id;
    logic [IVL_W-1:0] interval;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

  // Status returned by each cell to the controller.
  typedef struct packed {
    logic            tok;
    logic            tok_due;
    logic            tok_later;
    logic [ID_W-1:0] fired_id;
  } cell_stat_t;

endpackage

>>> rtl/pts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task slot scheduler: slot cell
// Holds one task slot and a scan token. Takes its upper neighbour's slot on
// a removal, and hands the scan token to the next cell on each scan step.
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pts_pkg::CNT_W-1:0]  cell_idx_i,
  input  pts_pkg::cell_cmd_t         cmd_i,
  input  pts_pkg::slot_t             above_i,
  input  logic                       match_prev_i,
  output logic                       match_o,
  input  logic                       due_next_i,
  output logic                       due_o,
  input  logic                       tok_prev_i,
  output pts_pkg::slot_t             slot_o,
  output pts_pkg::cell_stat_t        stat_o
);

  pts_pkg::slot_t slot_q, slot_d;
  logic           tok_q, tok_d;
  logic           occupied;
  logic           hit;
  logic           due_here;

  // Local decodes: occupancy, id match and countdown expiry.
  assign occupied = (cell_idx_i < cmd_i.count);
  assign hit      = occupied && (slot_q.id == cmd_i.key_id);
  assign due_here = occupied && (slot_q.countdown == '0);
  assign match_o  = match_prev_i | hit;
  assign due_o    = due_here | due_next_i;

  // Status seen by the controller; only the token holder reports.
  always_comb begin
    stat_o.tok       = tok_q;
    stat_o.tok_due   = tok_q & due_here;
    stat_o.tok_later = tok_q & due_next_i;
    stat_o.fired_id  = tok_q ? slot_q.id : '0;
  end

  assign slot_o = slot_q;

  // Next slot contents and token.
  always_comb begin
    slot_d = slot_q;
    tok_d  = tok_q;
    case (cmd_i.cmd)
      pts_pkg::CMD_ADD: begin
        if (cell_idx_i == cmd_i.count) begin
          slot_d.id        = cmd_i.key_id;
          slot_d.interval  = cmd_i.interval;
          slot_d.countdown = '0;
        end
      end
      pts_pkg::CMD_REMOVE: begin
        // The matching slot and every later one move down one place.
        if (match_o) begin
          slot_d = above_i;
        end
      end
      pts_pkg::CMD_DECR: begin
        if (slot_q.countdown != '0) begin
          slot_d.countdown = slot_q.countdown - pts_pkg::IVL_W'(1);
        end
        tok_d = (cell_idx_i == '0);
      end
      pts_pkg::CMD_SCAN: begin
        if (tok_q && due_here) begin
          slot_d.countdown = slot_q.interval;
        end
        tok_d = tok_prev_i;
      end
      default: begin
        slot_d = slot_q;
        tok_d  = tok_q;
      end
    endcase
  end

  // Slot storage needs no reset: only occupied slots are ever read.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

endmodule

>>> rtl/periodic_task_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task slot scheduler: top level
// Controller, output register and the row of slot cells.
// ----------------------------------------------------------------------------
// An add or remove transaction gives one result. A tick first counts down
// every slot; then a scan token walks the row of cells from slot zero,
// stopping after the last slot that is due, and gives one fired result per
// due slot in slot order, or one idle result if none is due. The token
// advances only while the output register can take a result, so a stalled
// result consumer lengthens the scan. A new input transaction is taken once
// the scan has ended and the output register is free or being emptied.
module periodic_task_slot_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pts_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pts_pkg::out_t  out_data_o
);

  localparam int unsigned N = pts_pkg::MAX_TASKS;

  pts_pkg::state_e            state_q, state_d;
  logic [pts_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       fired_any_q, fired_any_d;
  logic                       out_valid_q, out_valid_d;
  pts_pkg::out_t              out_q, out_d;
  logic                       out_load;
  logic                       out_free;
  logic                       in_acc;
  pts_pkg::cell_cmd_t         cmd;

  pts_pkg::slot_t             slot_w  [N];
  pts_pkg::slot_t             above_w [N];
  pts_pkg::cell_stat_t        stat_w  [N];
  logic                       match_w [N];
  logic                       due_w   [N];
  logic                       mprev_w [N];
  logic                       dnext_w [N];
  logic                       tprev_w [N];

  logic                       tok_due_any;
  logic                       tok_later_any;
  logic [pts_pkg::ID_W-1:0]   fired_id;

  // Handshake.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == pts_pkg::S_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Row of slot cells with neighbour links.
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign mprev_w[g] = 1'b0;
      assign tprev_w[g] = 1'b0;
    end else begin : g_rest
      assign mprev_w[g] = match_w[g-1];
      assign tprev_w[g] = stat_w[g-1].tok;
    end
    if (g == N - 1) begin : g_top
      assign dnext_w[g] = 1'b0;
      assign above_w[g] = slot_w[g];
    end else begin : g_mid
      assign dnext_w[g] = due_w[g+1];
      assign above_w[g] = slot_w[g+1];
    end

    pts_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (pts_pkg::CNT_W'(g)),
      .cmd_i        (cmd),
      .above_i      (above_w[g]),
      .match_prev_i (mprev_w[g]),
      .match_o      (match_w[g]),
      .due_next_i   (dnext_w[g]),
      .due_o        (due_w[g]),
      .tok_prev_i   (tprev_w[g]),
      .slot_o       (slot_w[g]),
      .stat_o       (stat_w[g])
    );
  end

  // Gather the token holder's report; at most one cell holds the token.
  always_comb begin
    tok_due_any   = 1'b0;
    tok_later_any = 1'b0;
    fired_id      = '0;
    for (int i = 0; i < N; i++) begin
      tok_due_any   = tok_due_any | stat_w[i].tok_due;
      tok_later_any = tok_later_any | stat_w[i].tok_later;
      fired_id      = fired_id | stat_w[i].fired_id;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::S_IDLE: begin
        if (in_acc && (in_data_i.op == pts_pkg::OP_TICK)) begin
          state_d = pts_pkg::S_SCAN;
        end
      end
      pts_pkg::S_SCAN: begin
        if (out_free && !tok_later_any) begin
          state_d = pts_pkg::S_IDLE;
        end
      end
      default: state_d = pts_pkg::S_IDLE;
    endcase
  end

  // Cell commands, slot count and result formation.
  always_comb begin
    cmd.cmd      = pts_pkg::CMD_HOLD;
    cmd.key_id   = in_data_i.task_id;
    cmd.interval = in_data_i.interval;
    cmd.count    = count_q;
    count_d      = count_q;
    fired_any_d  = fired_any_q;
    out_load     = 1'b0;
    out_d        = out_q;
    case (state_q)
      pts_pkg::S_IDLE: begin
        if (in_acc) begin
          out_d.task_id_res = in_data_i.task_id;
          out_d.last        = 1'b1;
          case (in_data_i.op)
            pts_pkg::OP_ADD: begin
              cmd.cmd  = pts_pkg::CMD_ADD;
              out_load = 1'b1;
              if (count_q < pts_pkg::CNT_W'(N)) begin
                count_d      = count_q + pts_pkg::CNT_W'(1);
                out_d.status = pts_pkg::ST_ADDED;
              end else begin
                out_d.status = pts_pkg::ST_FULL;
              end
            end
            pts_pkg::OP_REMOVE: begin
              cmd.cmd  = pts_pkg::CMD_REMOVE;
              out_load = 1'b1;
              if (match_w[N-1]) begin
                count_d      = count_q - pts_pkg::CNT_W'(1);
                out_d.status = pts_pkg::ST_REMOVED;
              end else begin
                out_d.status = pts_pkg::ST_NOT_FOUND;
              end
            end
            pts_pkg::OP_TICK: begin
              cmd.cmd     = pts_pkg::CMD_DECR;
              fired_any_d = 1'b0;
            end
            default: begin
              cmd.cmd = pts_pkg::CMD_HOLD;
            end
          endcase
          out_d.active_count = count_d[pts_pkg::AC_W-1:0];
        end
      end
      pts_pkg::S_SCAN: begin
        if (out_free) begin
          cmd.cmd            = pts_pkg::CMD_SCAN;
          out_d.active_count = count_q[pts_pkg::AC_W-1:0];
          if (tok_due_any) begin
            out_load          = 1'b1;
            out_d.status      = pts_pkg::ST_FIRED;
            out_d.task_id_res = fired_id;
            out_d.last        = !tok_later_any;
            fired_any_d       = 1'b1;
          end else if (!tok_later_any && !fired_any_q) begin
            out_load          = 1'b1;
            out_d.status      = pts_pkg::ST_IDLE;
            out_d.task_id_res = '0;
            out_d.last        = 1'b1;
          end
        end
      end
      default: begin
        cmd.cmd = pts_pkg::CMD_HOLD;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::S_IDLE;
      count_q     <= '0;
      fired_any_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fired_any_q <= fired_any_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // The slot count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pts_pkg::CNT_W'(N))
    else $error("slot count above table size");

  // The slot count only changes on an accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("slot count changed without an input transaction");

  // A final result loaded during a scan ends the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::S_SCAN && out_load && out_d.last) |=> state_q == pts_pkg::S_IDLE)
    else $error("scan continued after its final result");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");
`endif

endmodule
